FILE: src/ptq_pkg.sv
package ptq_pkg;

	localparam int ID_W         = 16;
	localparam int PRIO_W       = 8;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 3;
	localparam int OCC_W        = 5;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_POP    = 2'd2,
		FUNC_POP_X  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_ADDED   = 3'd0,
		STATUS_UPDATED = 3'd1,
		STATUS_POPPED  = 3'd2,
		STATUS_EMPTY   = 3'd3,
		STATUS_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic              remove;
		logic              insert;
		logic [ID_W-1:0]   key_id;
		logic [PRIO_W-1:0] key_prio;
	} cell_ctrl_t;

endpackage

FILE: src/ptq_cell.sv
module ptq_cell
	import ptq_pkg::*;
#(
	parameter int POS_W = 4,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [POS_W-1:0] rm_pos,
	input  entry_t           prev,
	input  entry_t           next,
	output entry_t           entry,
	output logic             match
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	entry_t            cur;
	entry_t            entry_d;
	logic              take_new;
	logic              shift_right;

	assign cur   = '{valid: valid_q, id: id_q, prio: prio_q};
	assign match = cur.valid && (cur.id == ctrl.key_id);
	assign entry = cur;

	// sorted order lets each cell find the insert point from its left neighbor alone
	assign take_new = prev.valid && (prev.prio >= ctrl.key_prio) &&
		(!cur.valid || (cur.prio < ctrl.key_prio));
	assign shift_right = prev.valid && (prev.prio < ctrl.key_prio);

	always_comb begin
		entry_d = cur;
		if (ctrl.remove) begin
			if (MY_POS >= rm_pos) begin
				entry_d = next;
			end
		end else if (ctrl.insert) begin
			if (take_new) begin
				entry_d.valid = 1'b1;
				entry_d.id    = ctrl.key_id;
				entry_d.prio  = ctrl.key_prio;
			end else if (shift_right) begin
				entry_d = prev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= entry_d.id;
		prio_q <= entry_d.prio;
	end

endmodule

FILE: src/priority_task_queue_with_update.sv
// Priority task queue: holds up to CAPACITY tasks (16-bit id, 8-bit priority) in a row of
// cells kept sorted by priority, oldest first among equal priorities. Each item is an add,
// an update or a pop; an add of a held id acts as an update, an update of an absent id adds
// the task (status added), and an add into a full queue is rejected with status full. Every
// item gives one result with the status, the popped task (zero unless popped) and the
// occupancy after the operation. Each item goes through a search of all cells for the id, a
// shift of the row to close the removed slot (a pop or a move of a held task), a shift that
// opens the insert slot (an add of a new task or a move of a held task) and the load of the
// output register, in that order; an empty pop or a full rejection goes from the search
// straight to the load. The next item can be taken in the cycle after the result is loaded,
// even while that result waits on m_tready; a result still waiting when the next one is
// ready holds the block in its done state.
module priority_task_queue_with_update
	import ptq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // func[1:0], task_id[17:2], priority_value[25:18], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // status[2:0], out_id[18:3], out_priority[26:19], occupancy[31:27]
);

	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FIND   = 5'b00010,
		ST_REMOVE = 5'b00100,
		ST_INSERT = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t            state_q;
	logic              pop_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count_q;
	status_t           status_q;
	logic [ID_W-1:0]   rid_q;
	logic [PRIO_W-1:0] rprio_q;
	logic              m_valid_q;
	logic [31:0]       m_data_q;

	entry_t            cells [CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] valid_vec;
	logic [POS_W-1:0]  match_pos;
	cell_ctrl_t        ctrl;
	entry_t            head_tie;
	entry_t            tail_tie;
	logic              accept;
	logic              out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// head sees a full-priority neighbor so it can take a new task, tail shifts in empty
	assign head_tie = '{valid: 1'b1, id: '0, prio: '1};
	assign tail_tie = '{valid: 1'b0, id: '0, prio: '0};

	always_comb begin
		ctrl.remove   = (state_q == ST_REMOVE);
		ctrl.insert   = (state_q == ST_INSERT);
		ctrl.key_id   = id_q;
		ctrl.key_prio = prio_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = head_tie;
		end else begin : g_mid_prev
			assign prev_e = cells[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = tail_tie;
		end else begin : g_mid_next
			assign next_e = cells[i+1];
		end
		ptq_cell #(
			.POS_W (POS_W),
			.IDX   (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.rm_pos (pos_q),
			.prev   (prev_e),
			.next   (next_e),
			.entry  (cells[i]),
			.match  (match_vec[i])
		);
		assign valid_vec[i] = cells[i].valid;
	end

	// ids are unique among held tasks, so an or of indexes encodes the single match
	always_comb begin
		match_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				match_pos = match_pos | POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (pop_q) begin
						state_q <= (count_q == '0) ? ST_DONE : ST_REMOVE;
					end else if (|match_vec) begin
						state_q <= ST_REMOVE;
					end else if (count_q == CNT_MAX) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_INSERT;
					end
				end
				ST_REMOVE: begin
					count_q <= count_q - 1'b1;
					state_q <= pop_q ? ST_DONE : ST_INSERT;
				end
				ST_INSERT: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_q  <= s_tdata[1];
			id_q   <= s_tdata[17:2];
			prio_q <= s_tdata[25:18];
		end
		if (state_q == ST_FIND) begin
			if (pop_q) begin
				pos_q <= '0;
				if (count_q == '0) begin
					status_q <= STATUS_EMPTY;
					rid_q    <= '0;
					rprio_q  <= '0;
				end else begin
					status_q <= STATUS_POPPED;
					rid_q    <= cells[0].id;
					rprio_q  <= cells[0].prio;
				end
			end else begin
				pos_q   <= match_pos;
				rid_q   <= '0;
				rprio_q <= '0;
				if (|match_vec) begin
					status_q <= STATUS_UPDATED;
				end else if (count_q == CNT_MAX) begin
					status_q <= STATUS_FULL;
				end else begin
					status_q <= STATUS_ADDED;
				end
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q[2:0]   <= status_q;
			m_data_q[18:3]  <= rid_q;
			m_data_q[26:19] <= rprio_q;
			m_data_q[31:27] <= OCC_W'(count_q);
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("occupancy above capacity");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("occupancy differs from held cells");

	a_cells_compact: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("held cells not packed at the head");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND |-> $onehot0(match_vec))
		else $error("task id held in more than one cell");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add one task");
`endif

endmodule
